FILE: hw/rtl/kev_pkg.sv
// ----------------------------------------------------------------------------
// kev_pkg: shared definitions for the k-mer extension vote block
// Field widths, choice codes, register indexes and the per-base rating.
// ----------------------------------------------------------------------------
package kev_pkg;

  localparam int FIELD_W    = 16;  // width of every vote count and of depth
  localparam int FACTOR_W   = 16;  // Q4.12 factor width
  localparam int FRAC_BITS  = 12;
  localparam int THR_W      = FIELD_W + FACTOR_W;
  localparam int RATE_W     = 3;
  localparam int CHOICE_W   = 3;
  localparam int RATIO_W    = 3;   // rating threshold register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_BASES  = 4;
  localparam int RANK_W     = 2;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [THR_W-1:0] FLOOR_Q = THR_W'(2) << FRAC_BITS;

  // Choice codes
  localparam logic [CHOICE_W-1:0] CH_A    = 3'd0;
  localparam logic [CHOICE_W-1:0] CH_C    = 3'd1;
  localparam logic [CHOICE_W-1:0] CH_G    = 3'd2;
  localparam logic [CHOICE_W-1:0] CH_T    = 3'd3;
  localparam logic [CHOICE_W-1:0] CH_FORK = 3'd4;
  localparam logic [CHOICE_W-1:0] CH_NONE = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VIABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // Reset values
  localparam logic [FACTOR_W-1:0] VIABLE_RST    = 16'd819;
  localparam logic [FACTOR_W-1:0] EXPECTED_RST  = 16'd1229;
  localparam logic [RATIO_W-1:0]  THRESHOLD_RST = 3'd2;

  // Rating 0..7 of one base from its all-quality (n) and high-quality (h)
  // votes against the viable (v_q) and expected (e_q) thresholds in Q.12.
  function automatic logic [RATE_W-1:0] rate_base(
    input logic [FIELD_W-1:0] n,
    input logic [FIELD_W-1:0] h,
    input logic [THR_W-1:0]   v_q,
    input logic [THR_W-1:0]   e_q
  );
    logic [THR_W-1:0]   nq;
    logic [THR_W-1:0]   hq;
    logic [RATE_W-1:0]  r;
    nq = THR_W'(n) << FRAC_BITS;
    hq = THR_W'(h) << FRAC_BITS;
    if (n == '0)                          r = 3'd0;
    else if (n == FIELD_W'(1))            r = 3'd1;
    else if (nq < v_q)                    r = 3'd2;
    else if (nq < e_q)                    r = (hq < v_q) ? 3'd3 : 3'd4;
    else if (hq < v_q)                    r = 3'd5;
    else if (hq > v_q && hq < e_q)        r = 3'd6;
    else                                  r = 3'd7;
    return r;
  endfunction

endpackage

FILE: hw/rtl/kev_in_if.sv
// ----------------------------------------------------------------------------
// kev_in_if: input channel of the k-mer extension vote block
// One beat carries the eight vote counts and the contig depth.
// ----------------------------------------------------------------------------
interface kev_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] hi_a;
  logic [15:0] hi_c;
  logic [15:0] hi_g;
  logic [15:0] hi_t;
  logic [15:0] lo_a;
  logic [15:0] lo_c;
  logic [15:0] lo_g;
  logic [15:0] lo_t;
  logic [15:0] depth;

  modport source (
    output valid, hi_a, hi_c, hi_g, hi_t, lo_a, lo_c, lo_g, lo_t, depth,
    input  ready
  );
  modport sink (
    input  valid, hi_a, hi_c, hi_g, hi_t, lo_a, lo_c, lo_g, lo_t, depth,
    output ready
  );
endinterface

FILE: hw/rtl/kev_out_if.sv
// ----------------------------------------------------------------------------
// kev_out_if: result channel of the k-mer extension vote block
// One beat carries the chosen extension and its vote count.
// ----------------------------------------------------------------------------
interface kev_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  choice;
  logic [15:0] vote_count;

  modport source (output valid, choice, vote_count, input ready);
  modport sink (input valid, choice, vote_count, output ready);
endinterface

FILE: hw/rtl/kev_cfg_if.sv
// ----------------------------------------------------------------------------
// kev_cfg_if: register write channel of the k-mer extension vote block
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface kev_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/kev_thresh.sv
// ----------------------------------------------------------------------------
// kev_thresh: threshold stage
// Multiplies depth by both factors, floors at 2.0 and registers the
// thresholds together with the vote counts.
// ----------------------------------------------------------------------------
module kev_thresh #(
  parameter int CNT_W = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [kev_pkg::FIELD_W-1:0]            depth,
  input  logic [kev_pkg::FACTOR_W-1:0]           viable_factor,
  input  logic [kev_pkg::FACTOR_W-1:0]           expected_factor,
  input  logic [CNT_W-1:0]                       hi_in [kev_pkg::NUM_BASES],
  input  logic [CNT_W-1:0]                       lo_in [kev_pkg::NUM_BASES],
  output logic [kev_pkg::THR_W-1:0]              v_q,
  output logic [kev_pkg::THR_W-1:0]              e_q,
  output logic [CNT_W-1:0]                       hi_q [kev_pkg::NUM_BASES],
  output logic [CNT_W-1:0]                       lo_q [kev_pkg::NUM_BASES]
);
  import kev_pkg::*;

  logic [THR_W-1:0] v_prod;
  logic [THR_W-1:0] e_prod;

  assign v_prod = THR_W'(depth) * THR_W'(viable_factor);
  assign e_prod = THR_W'(depth) * THR_W'(expected_factor);

  always_ff @(posedge clk) begin
    if (en) begin
      v_q  <= (v_prod < FLOOR_Q) ? FLOOR_Q : v_prod;
      e_q  <= (e_prod < FLOOR_Q) ? FLOOR_Q : e_prod;
      hi_q <= hi_in;
      lo_q <= lo_in;
    end
  end

endmodule

FILE: hw/rtl/kev_vote.sv
// ----------------------------------------------------------------------------
// kev_vote: rating, ordering and decision stage
// Rates each base, ranks the bases by (rating, hi, lo) with A,C,G,T tie
// order, picks base / fork / none and registers the result.
// ----------------------------------------------------------------------------
module kev_vote #(
  parameter int CNT_W = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [kev_pkg::THR_W-1:0]     v_q,
  input  logic [kev_pkg::THR_W-1:0]     e_q,
  input  logic [CNT_W-1:0]              hi [kev_pkg::NUM_BASES],
  input  logic [CNT_W-1:0]              lo [kev_pkg::NUM_BASES],
  input  logic [kev_pkg::RATIO_W-1:0]   rating_threshold,
  output logic [kev_pkg::CHOICE_W-1:0]  choice,
  output logic [kev_pkg::FIELD_W-1:0]   vote_count
);
  import kev_pkg::*;

  localparam int KEY_W = RATE_W + 2 * CNT_W;

  logic [RATE_W-1:0]   rt    [NUM_BASES];
  logic [KEY_W-1:0]    key   [NUM_BASES];
  logic [RANK_W-1:0]   rank  [NUM_BASES];
  logic [RANK_W-1:0]   ia, ib, ic;
  logic [RATE_W-1:0]   r0, r1, r2;
  logic [CNT_W-1:0]    lo_a, lo_b;
  logic [CHOICE_W-1:0] choice_next;
  logic [FIELD_W-1:0]  count_next;

  always_comb begin
    for (int i = 0; i < NUM_BASES; i++) begin
      rt[i]  = rate_base(FIELD_W'(lo[i]), FIELD_W'(hi[i]), v_q, e_q);
      key[i] = {rt[i], hi[i], lo[i]};
    end
  end

  // rank = number of bases ahead: strictly larger key, or equal key earlier
  always_comb begin
    for (int i = 0; i < NUM_BASES; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NUM_BASES; j++) begin
        if (j != i && (key[j] > key[i] || (key[j] == key[i] && j < i)))
          rank[i] = rank[i] + RANK_W'(1);
      end
    end
  end

  always_comb begin
    ia = '0;
    ib = '0;
    ic = '0;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (rank[i] == RANK_W'(0)) ia = RANK_W'(i);
      if (rank[i] == RANK_W'(1)) ib = RANK_W'(i);
      if (rank[i] == RANK_W'(2)) ic = RANK_W'(i);
    end
  end

  assign r0   = rt[ia];
  assign r1   = rt[ib];
  assign r2   = rt[ic];
  assign lo_a = lo[ia];
  assign lo_b = lo[ib];

  always_comb begin
    choice_next = CH_NONE;
    count_next  = '0;
    if (r0 > rating_threshold) begin
      if (r0 <= 3'd3) begin
        if (r1 == 3'd0) choice_next = CHOICE_W'(ia);
      end else if (r0 < 3'd6) begin
        if (r1 < 3'd3) choice_next = CHOICE_W'(ia);
      end else if (r0 == 3'd6) begin
        if (r1 < 3'd4) choice_next = CHOICE_W'(ia);
      end else if (r1 < 3'd7) begin
        choice_next = CHOICE_W'(ia);
      end else if (r2 == 3'd7 || lo_a == lo_b) begin
        choice_next = CH_FORK;
      end else if (lo_a > lo_b) begin
        choice_next = CHOICE_W'(ia);
      end else begin
        choice_next = CHOICE_W'(ib);
      end
    end
    if (choice_next < CH_FORK)
      count_next = FIELD_W'(lo[choice_next[RANK_W-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      choice     <= choice_next;
      vote_count <= count_next;
    end
  end

endmodule

FILE: hw/rtl/kmer_extension_vote.sv
// ----------------------------------------------------------------------------
// kmer_extension_vote: next-base vote for a local-assembly walk
// Three-stage pipeline from k-mer vote counts to base / fork / none.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one result beat per input beat, in
// order. The beat is captured in the input register on acceptance, the
// depth-times-factor multipliers feed the threshold register, and rating,
// ranking and decision feed the output register. Throughput is one beat per
// cycle; vote_in.ready only drops when all three stages hold a beat and the
// result is not being taken. Registers (viable_factor, expected_factor,
// rating_threshold) are written through cfg, which is always ready; write
// them only while the pipeline is empty. Vote counts are used in their low
// COUNT_BITS bits (at most 16).
// ----------------------------------------------------------------------------
module kmer_extension_vote #(
  parameter int COUNT_BITS = kev_pkg::COUNT_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  kev_in_if.sink    vote_in,
  kev_out_if.source vote_out,
  kev_cfg_if.sink   cfg
);
  import kev_pkg::*;

  // effective count width: fields are only 16 bits wide
  localparam int CNT_W = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;

  // configuration
  logic [FACTOR_W-1:0] viable_factor;
  logic [FACTOR_W-1:0] expected_factor;
  logic [RATIO_W-1:0]  rating_threshold;

  // pipeline occupancy and advance enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1 payload
  logic [FIELD_W-1:0] depth1;
  logic [CNT_W-1:0]   hi1 [NUM_BASES];
  logic [CNT_W-1:0]   lo1 [NUM_BASES];

  // stage 2 payload
  logic [THR_W-1:0]   v_q2;
  logic [THR_W-1:0]   e_q2;
  logic [CNT_W-1:0]   hi2 [NUM_BASES];
  logic [CNT_W-1:0]   lo2 [NUM_BASES];

  // register writes; an index past the list is dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      viable_factor    <= VIABLE_RST;
      expected_factor  <= EXPECTED_RST;
      rating_threshold <= THRESHOLD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_VIABLE:    viable_factor    <= cfg.data[FACTOR_W-1:0];
        REG_EXPECTED:  expected_factor  <= cfg.data[FACTOR_W-1:0];
        REG_THRESHOLD: rating_threshold <= cfg.data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on
  assign en3 = !v3 || vote_out.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign vote_in.ready  = en1;
  assign vote_out.valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= vote_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // input register, counts trimmed to CNT_W
  always_ff @(posedge clk) begin
    if (en1) begin
      depth1 <= vote_in.depth;
      hi1[0] <= vote_in.hi_a[CNT_W-1:0];
      hi1[1] <= vote_in.hi_c[CNT_W-1:0];
      hi1[2] <= vote_in.hi_g[CNT_W-1:0];
      hi1[3] <= vote_in.hi_t[CNT_W-1:0];
      lo1[0] <= vote_in.lo_a[CNT_W-1:0];
      lo1[1] <= vote_in.lo_c[CNT_W-1:0];
      lo1[2] <= vote_in.lo_g[CNT_W-1:0];
      lo1[3] <= vote_in.lo_t[CNT_W-1:0];
    end
  end

  kev_thresh #(.CNT_W(CNT_W)) u_thresh (
    .clk             (clk),
    .en              (en2),
    .depth           (depth1),
    .viable_factor   (viable_factor),
    .expected_factor (expected_factor),
    .hi_in           (hi1),
    .lo_in           (lo1),
    .v_q             (v_q2),
    .e_q             (e_q2),
    .hi_q            (hi2),
    .lo_q            (lo2)
  );

  kev_vote #(.CNT_W(CNT_W)) u_vote (
    .clk              (clk),
    .en               (en3),
    .v_q              (v_q2),
    .e_q              (e_q2),
    .hi               (hi2),
    .lo               (lo2),
    .rating_threshold (rating_threshold),
    .choice           (vote_out.choice),
    .vote_count       (vote_out.vote_count)
  );

  // fork and no-extension carry no count
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (v3 && (vote_out.choice == CH_FORK || vote_out.choice == CH_NONE))
      |-> vote_out.vote_count == '0)
    else $error("nonzero count on fork or none");

  // back-pressure only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !vote_in.ready |-> (v1 && v2 && v3))
    else $error("input stalled with a free stage");

  // an accepted beat lands in the input register
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (vote_in.valid && vote_in.ready) |=> v1)
    else $error("accepted beat lost");

  // reported count never exceeds the count width
  a_count_width: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (vote_out.vote_count >> CNT_W) == '0)
    else $error("vote count wider than count width");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kmer_extension_vote
// Drives vote beats through a ready/valid channel with random gaps, predicts
// each result from an independent model of the rating, ordering and decision
// logic, and compares every result beat field by field. Register settings
// step through defaults, extremes, crossed thresholds and random values.
// ----------------------------------------------------------------------------
module testbench;
  import kev_pkg::*;

  localparam int LATENCY     = 2;       // input beat to result beat
  localparam int CYCLE_LIMIT = 300000;  // slowest clean run is far below this

  // Index 3 is not a register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One vote beat; element 0 is base A, then C, G, T.
  typedef struct packed {
    logic [NUM_BASES-1:0][FIELD_W-1:0] hi;
    logic [NUM_BASES-1:0][FIELD_W-1:0] lo;
    logic [FIELD_W-1:0]                depth;
  } votes_t;

  // One result beat.
  typedef struct packed {
    logic [CHOICE_W-1:0] choice;
    logic [FIELD_W-1:0]  count;
  } extension_t;

  logic clk;
  logic rst;

  kev_in_if  vote_in ();
  kev_out_if vote_out ();
  kev_cfg_if cfg ();

  kmer_extension_vote uut (
    .clk      (clk),
    .rst      (rst),
    .vote_in  (vote_in),
    .vote_out (vote_out),
    .cfg      (cfg)
  );

  // Local copy of the register file, tracked on every accepted write.
  logic [FACTOR_W-1:0] viable_q12;
  logic [FACTOR_W-1:0] expected_q12;
  logic [RATIO_W-1:0]  min_rating;

  extension_t pending_ext[$];   // predicted results, oldest first
  bit         no_gaps;          // both sides run flat out while set
  int         errors;
  int         votes_sent;
  int         results_checked;
  int         settings_run;
  int         cycle_count;
  int         choice_tally [8];

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [CHOICE_W-1:0] base_choice(input int b);
    case (b)
      0:       return CH_A;
      1:       return CH_C;
      2:       return CH_G;
      default: return CH_T;
    endcase
  endfunction

  // Rating 0..7 of one base; n all-quality votes, h high-quality votes,
  // thresholds in Q.12 so that every comparison is exact.
  function automatic logic [RATE_W-1:0] grade_base(
    input logic [FIELD_W-1:0] n,
    input logic [FIELD_W-1:0] h,
    input logic [63:0]        vq,
    input logic [63:0]        eq
  );
    logic [63:0] nq;
    logic [63:0] hq;
    nq = 64'(n) << FRAC_BITS;
    hq = 64'(h) << FRAC_BITS;
    if (n == 0) return 3'd0;
    if (n == 1) return 3'd1;
    if (nq < vq) return 3'd2;
    if (nq < eq) return (hq < vq) ? 3'd3 : 3'd4;
    if (hq < vq) return 3'd5;
    if (hq > vq && hq < eq) return 3'd6;
    return 3'd7;
  endfunction

  function automatic extension_t predict_extension(input votes_t v);
    logic [63:0]       vq;
    logic [63:0]       eq;
    logic [63:0]       floor_q;
    logic [RATE_W-1:0] grade [NUM_BASES];
    logic [34:0]       sort_key [NUM_BASES];
    int                place [NUM_BASES];
    int                at_place [NUM_BASES];
    int                a;
    int                b;
    int                pick;
    extension_t        r;
    floor_q = 64'd2 << FRAC_BITS;
    vq = 64'(v.depth) * 64'(viable_q12);
    eq = 64'(v.depth) * 64'(expected_q12);
    if (vq < floor_q) vq = floor_q;
    if (eq < floor_q) eq = floor_q;
    for (int i = 0; i < NUM_BASES; i++) begin
      grade[i]    = grade_base(v.lo[i], v.hi[i], vq, eq);
      sort_key[i] = {grade[i], v.hi[i], v.lo[i]};
    end
    // descending by key; on equal keys the lower base index goes first
    for (int i = 0; i < NUM_BASES; i++) begin
      place[i] = 0;
      for (int j = 0; j < NUM_BASES; j++) begin
        if (j != i && (sort_key[j] > sort_key[i] ||
                       (sort_key[j] == sort_key[i] && j < i))) begin
          place[i]++;
        end
      end
    end
    for (int i = 0; i < NUM_BASES; i++) at_place[place[i]] = i;
    a    = at_place[0];
    b    = at_place[1];
    pick = -1;
    r.choice = CH_NONE;
    r.count  = '0;
    if (grade[a] > min_rating) begin
      if (grade[a] <= 3) begin
        if (grade[b] == 0) pick = a;
      end else if (grade[a] <= 5) begin
        if (grade[b] < 3) pick = a;
      end else if (grade[a] == 6) begin
        if (grade[b] < 4) pick = a;
      end else if (grade[b] != 7) begin
        pick = a;
      end else if (grade[at_place[2]] == 7 || v.lo[a] == v.lo[b]) begin
        r.choice = CH_FORK;
      end else begin
        pick = (v.lo[a] > v.lo[b]) ? a : b;
      end
    end
    if (pick >= 0) begin
      r.choice = base_choice(pick);
      r.count  = v.lo[pick];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic votes_t votes9(
    input int d,
    input int ha, input int hc, input int hg, input int ht,
    input int la, input int lc, input int lg, input int lt
  );
    votes_t v;
    v.depth = 16'(d);
    v.hi    = {16'(ht), 16'(hg), 16'(hc), 16'(ha)};
    v.lo    = {16'(lt), 16'(lg), 16'(lc), 16'(la)};
    return v;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp_count(input longint x);
    if (x < 0) return '0;
    if (x > 65535) return '1;
    return x[FIELD_W-1:0];
  endfunction

  // Vote count biased towards the rating boundaries around V and E.
  function automatic logic [FIELD_W-1:0] pick_count(input longint vi, input longint ei);
    case ($urandom_range(0, 7))
      0:       return FIELD_W'($urandom_range(0, 1));
      1:       return clamp_count(vi + int'($urandom_range(0, 2)) - 1);
      2:       return clamp_count(ei + int'($urandom_range(0, 2)) - 1);
      3:       return FIELD_W'($urandom);
      4:       return FIELD_W'($urandom_range(0, 15));
      default: return clamp_count(2 + longint'($urandom_range(0, int'(ei + ei / 2))));
    endcase
  endfunction

  function automatic votes_t random_votes();
    votes_t v;
    longint vq;
    longint eq;
    int     sel;
    if ($urandom_range(0, 9) == 0) begin
      // noise: every field anywhere in its range
      for (int i = 0; i < NUM_BASES; i++) begin
        v.hi[i] = FIELD_W'($urandom);
        v.lo[i] = FIELD_W'($urandom);
      end
      v.depth = FIELD_W'($urandom);
      return v;
    end
    sel = $urandom_range(0, 19);
    if (sel < 12)      v.depth = FIELD_W'($urandom_range(0, 300));
    else if (sel < 17) v.depth = FIELD_W'($urandom_range(0, 4095));
    else               v.depth = FIELD_W'($urandom);
    vq = longint'(v.depth) * longint'(viable_q12);
    eq = longint'(v.depth) * longint'(expected_q12);
    if (vq < 8192) vq = 8192;
    if (eq < 8192) eq = 8192;
    for (int i = 0; i < NUM_BASES; i++) begin
      v.lo[i] = pick_count(vq >> FRAC_BITS, eq >> FRAC_BITS);
      v.hi[i] = ($urandom_range(0, 3) == 0) ? v.lo[i]
                                            : pick_count(vq >> FRAC_BITS, eq >> FRAC_BITS);
      // empty bases leave room for a single winner
      if ($urandom_range(0, 3) == 0) v.lo[i] = '0;
      // equal keys on neighbours exercise the ordering ties
      if (i > 0 && $urandom_range(0, 6) == 0) begin
        v.hi[i] = v.hi[i-1];
        v.lo[i] = v.lo[i-1];
      end
    end
    return v;
  endfunction

  // One vote beat: optional gap, then hold valid until accepted.
  task automatic send_votes(input votes_t v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      vote_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vote_in.hi_a  <= v.hi[0];
    vote_in.hi_c  <= v.hi[1];
    vote_in.hi_g  <= v.hi[2];
    vote_in.hi_t  <= v.hi[3];
    vote_in.lo_a  <= v.lo[0];
    vote_in.lo_c  <= v.lo[1];
    vote_in.lo_g  <= v.lo[2];
    vote_in.lo_t  <= v.lo[3];
    vote_in.depth <= v.depth;
    vote_in.valid <= 1'b1;
    do @(posedge clk); while (!vote_in.ready);
    // config cannot change while beats are in flight, so predict now
    pending_ext.insert(pending_ext.size(), predict_extension(v));
    votes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data  <= data;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_VIABLE:    viable_q12   = data;
      REG_EXPECTED:  expected_q12 = data;
      REG_THRESHOLD: min_rating   = data[RATIO_W-1:0];
      default:       ;  // unmapped index, dropped by the block
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Drop valid and wait until the pipeline has drained.
  task automatic quiesce();
    @(negedge clk);
    vote_in.valid <= 1'b0;
    while (pending_ext.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      // now and then a stretch with no gaps on either side
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_votes(random_votes());
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: V = 0.2 depth, E = 0.3 depth, top rating must beat 2.
  task automatic test_reset_settings();
    settings_run++;
    send_votes(votes9(0, 0, 0, 0, 0, 0, 0, 0, 0));                   // nothing at all
    send_votes(votes9(65535, 65535, 65535, 65535, 65535,
                      65535, 65535, 65535, 65535));                   // four top ratings
    send_votes(votes9(10, 0, 0, 0, 0, 0, 1, 0, 0));                   // single vote
    send_votes(votes9(10, 0, 0, 50, 0, 0, 0, 50, 0));                 // clear winner G
    send_votes(votes9(10, 40, 0, 0, 40, 40, 0, 0, 40));               // equal counts fork
    send_votes(votes9(10, 50, 40, 0, 0, 60, 90, 0, 0));               // runner-up wins on count
    send_votes(votes9(10, 50, 0, 50, 0, 60, 0, 70, 0));               // tie on hi, lo decides
    send_votes(votes9(0, 5, 5, 5, 5, 5, 5, 5, 5));                    // all equal, floor of 2
    // depth 100: V just under 20, E just over 30
    send_votes(votes9(100, 25, 5, 0, 0, 40, 25, 0, 0));               // 6 over 3
    send_votes(votes9(100, 25, 25, 0, 0, 40, 25, 0, 0));              // 6 over 4: none
    send_votes(votes9(100, 0, 0, 5, 0, 0, 0, 40, 10));                // 5 over 2
    send_votes(votes9(100, 0, 0, 5, 5, 0, 0, 40, 25));                // 5 over 3: none
    send_votes(votes9(100, 0, 25, 0, 0, 1, 25, 0, 0));                // 4 over 1
    send_votes(votes9(100, 0, 0, 0, 0, 0, 0, 0, 25));                 // lone 3
    send_votes(votes9(100, 0, 0, 0, 0, 1, 0, 0, 25));                 // 3 over 1: none
    send_votes(votes9(100, 0, 0, 0, 0, 0, 0, 10, 0));                 // 2 not above threshold
    // depth 4096: counts land exactly on V = 819 and E = 1229
    send_votes(votes9(4096, 819, 818, 0, 0, 1229, 1228, 0, 0));
    run_random(250);
  endtask

  // V = depth, E = 2 depth, any rating above 0 may extend.
  task automatic test_low_threshold();
    quiesce();
    write_reg(REG_VIABLE, 16'd4096);
    write_reg(REG_EXPECTED, 16'd8192);
    write_reg(REG_THRESHOLD, 16'd0);
    settings_run++;
    send_votes(votes9(10, 0, 0, 0, 0, 0, 1, 0, 0));                   // lone 1
    send_votes(votes9(10, 0, 0, 0, 0, 0, 1, 0, 1));                   // two 1s: none
    send_votes(votes9(10, 0, 0, 0, 0, 5, 0, 0, 0));                   // lone 2
    send_votes(votes9(10, 0, 0, 0, 0, 5, 0, 1, 0));                   // 2 over 1: none
    send_votes(votes9(0, 0, 0, 0, 2, 0, 0, 0, 2));                    // floor thresholds
    send_votes(votes9(10, 10, 11, 0, 0, 30, 30, 0, 0));               // hi exactly V is not 6
    send_votes(votes9(10, 0, 0, 10, 0, 0, 0, 15, 0));                 // hi exactly V gives 4
    run_random(150);
  endtask

  // Largest factors, threshold 7: nothing may ever extend.
  task automatic test_closed_threshold();
    quiesce();
    write_reg(REG_VIABLE, 16'hFFFF);
    write_reg(REG_EXPECTED, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    settings_run++;
    send_votes(votes9(1, 100, 0, 0, 0, 100, 0, 0, 0));
    send_votes(votes9(65535, 65535, 0, 0, 0, 65535, 0, 0, 0));
    run_random(100);
  endtask

  // Zero factors: both thresholds sit on the floor of 2.
  task automatic test_zero_factors();
    quiesce();
    write_reg(REG_VIABLE, 16'd0);
    write_reg(REG_EXPECTED, 16'd0);
    write_reg(REG_THRESHOLD, 16'h0A03);   // upper bits are not stored
    settings_run++;
    send_votes(votes9(65535, 1, 0, 0, 0, 2, 0, 0, 0));
    run_random(150);
  endtask

  // Viable above expected: ratings 3, 4 and 6 cannot occur.
  task automatic test_crossed_factors();
    quiesce();
    write_reg(REG_VIABLE, 16'd12288);
    write_reg(REG_EXPECTED, 16'd4096);
    write_reg(REG_THRESHOLD, 16'd1);
    write_reg(REG_SPARE, 16'd0);
    settings_run++;
    run_random(150);
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] thr_word;
    for (int k = 0; k < 3; k++) begin
      quiesce();
      thr_word = CFG_DATA_W'($urandom);
      write_reg(REG_VIABLE, CFG_DATA_W'($urandom));
      write_reg(REG_EXPECTED, CFG_DATA_W'($urandom));
      write_reg(REG_THRESHOLD, thr_word);
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      settings_run++;
      run_random(150);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, one stall draw per beat
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    vote_out.ready = 1'b0;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (stall > 0) begin
        vote_out.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      vote_out.ready <= 1'b1;
      do @(posedge clk); while (!vote_out.valid);
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    extension_t want;
    if (!rst && vote_out.valid && vote_out.ready) begin
      if (pending_ext.size() == 0) begin
        $display("%0t: unexpected result beat, choice %0d count %0d",
                 $time, vote_out.choice, vote_out.vote_count);
        errors++;
      end else begin
        want = pending_ext.pop_front();
        results_checked++;
        choice_tally[want.choice]++;
        if (vote_out.choice !== want.choice) begin
          $display("%0t: choice expected %0d actual %0d",
                   $time, want.choice, vote_out.choice);
          errors++;
        end
        if (vote_out.vote_count !== want.count) begin
          $display("%0t: vote_count expected %0d actual %0d",
                   $time, want.count, vote_out.vote_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out with %0d results outstanding", $time, pending_ext.size());
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    clk             = 1'b0;
    rst             = 1'b1;
    no_gaps         = 1'b0;
    errors          = 0;
    votes_sent      = 0;
    results_checked = 0;
    settings_run    = 0;
    for (int i = 0; i < 8; i++) choice_tally[i] = 0;
    viable_q12      = VIABLE_RST;
    expected_q12    = EXPECTED_RST;
    min_rating      = THRESHOLD_RST;
    vote_in.valid   = 1'b0;
    vote_in.hi_a    = '0;
    vote_in.hi_c    = '0;
    vote_in.hi_g    = '0;
    vote_in.hi_t    = '0;
    vote_in.lo_a    = '0;
    vote_in.lo_c    = '0;
    vote_in.lo_g    = '0;
    vote_in.lo_t    = '0;
    vote_in.depth   = '0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_VIABLE;
    cfg.data        = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_low_threshold();
    test_closed_threshold();
    test_zero_factors();
    test_crossed_factors();
    test_random_settings();
    quiesce();

    $display("%0d vote beats over %0d register settings, %0d results checked",
             votes_sent, settings_run, results_checked);
    $display("outcomes A %0d C %0d G %0d T %0d fork %0d none %0d",
             choice_tally[CH_A], choice_tally[CH_C], choice_tally[CH_G],
             choice_tally[CH_T], choice_tally[CH_FORK], choice_tally[CH_NONE]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
